// File: design/swz_pkg.sv
// ----------------------------------------------------------------------------
// swz_pkg: shared types and constants of the sliding window z-score detector
// Holds field widths, register indexes, controller states and the command
// and status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package swz_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int SAMPLE_W   = 16;
  localparam int SLOT_W     = $clog2(WINDOW_MAX);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int SUM_W      = SAMPLE_W + SLOT_W;
  localparam int SQS_W      = 2 * SAMPLE_W + SLOT_W;
  localparam int D_W        = SQS_W + CNT_W;
  localparam int DEV_W      = SUM_W;
  localparam int Z_W        = 16;
  localparam int Q_W        = 2 * Z_W;
  localparam int THR_W      = 16;
  localparam int WIN_REG_W  = 7;
  localparam int CFG_W      = 16;
  localparam int ITER_W     = 5;

  localparam logic [WIN_REG_W-1:0] WINDOW_RESET = WIN_REG_W'(60);
  localparam logic [THR_W-1:0]     THRESH_RESET = THR_W'(768);

  typedef enum logic [0:0] {
    CFG_WINDOW_SIZE = 1'b0,
    CFG_Z_THRESHOLD = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_ACC,
    S_MUL,
    S_DEV,
    S_MUL2,
    S_CHK,
    S_DIV,
    S_SQRT,
    S_FIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic sq;
    logic acc;
    logic mul;
    logic dev;
    logic mul2;
    logic chk;
    logic div;
    logic sqrt;
    logic fin;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic sat;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: design/swz_ctrl.sv
// ----------------------------------------------------------------------------
// swz_ctrl: sequencing controller
// Steps one sample through update, products and checks, then division and square root unless skipped or saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module swz_ctrl
  import swz_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  sts_t      sts,
  output cmd_t      cmd
);

  state_t              state_r, state_nxt;
  logic [ITER_W-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DEV;
      end
      S_DEV: begin
        cmd.dev   = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        cnt_nxt = '0;
        if (sts.skip || sts.sat) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (cnt_r == ITER_W'(Q_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SQRT: begin
        cmd.sqrt = 1'b1;
        if (cnt_r == ITER_W'(Z_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_SQ))
    else $error("accepted word did not start the update sequence");

  a_sqrt_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT) |-> (cnt_r <= ITER_W'(Z_W - 1)))
    else $error("square root step count out of range");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input not stalled while a word is in flight");

endmodule

`default_nettype wire

// File: design/swz_dp.sv
// ----------------------------------------------------------------------------
// swz_dp: datapath of the sliding window z-score detector
// Holds the sample ring, running sums, configuration, the bit-serial divider,
// the bit-serial square root and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swz_dp
  import swz_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [Z_W-1:0]           out_z_score,
  output logic                     out_anomaly,
  output logic                     out_scored
);

  logic [SAMPLE_W-1:0] hist_mem [WINDOW_MAX];

  logic [WIN_REG_W-1:0] window_r;
  logic [THR_W-1:0]     thresh_r;
  logic [CNT_W-1:0]     held_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [SUM_W-1:0]     sum_r;
  logic [SQS_W-1:0]     sqs_r;

  logic [SAMPLE_W-1:0]  x_r, rd_r, old_r;
  logic                 evict_r;
  logic [2*SAMPLE_W-1:0] xsq_r, oldsq_r;
  logic [D_W-1:0]       nq_r, d_r;
  logic [2*SUM_W-1:0]   s2_r;
  logic [SUM_W:0]       nx_r;
  logic [DEV_W-1:0]     dev_r;
  logic                 few_r;
  logic [2*DEV_W-1:0]   devsq_r;
  logic [Q_W-1:0]       t2_r;
  logic [D_W-1:0]       rem_r;
  logic [Q_W-1:0]       num_r, q_r;
  logic [Z_W-1:0]       k_r, bit_r;
  logic [Z_W-1:0]       z_r;
  logic                 anom_r, scored_r;
  logic                 out_valid_r;
  logic [Z_W-1:0]       out_z_r;
  logic                 out_anom_r, out_scored_r;

  logic [CNT_W-1:0]     win;
  logic [SLOT_W-1:0]    old_idx;
  logic [D_W:0]         trial;
  logic [D_W:0]         trial_diff;
  logic [Z_W-1:0]       cand;
  logic [Q_W-1:0]       cand_sq;

  always_comb begin
    priority if (window_r == '0) begin
      win = CNT_W'(1);
    end else if (CNT_W'(window_r) > CNT_W'(WINDOW_MAX)) begin
      win = CNT_W'(WINDOW_MAX);
    end else begin
      win = CNT_W'(window_r);
    end
  end

  // Oldest held entry; a full ring of WINDOW_MAX wraps to the write slot.
  assign old_idx    = slot_r - held_r[SLOT_W-1:0];
  assign trial      = {rem_r, num_r[Q_W-1]};
  assign trial_diff = trial - {1'b0, d_r};
  assign cand       = k_r | bit_r;
  assign cand_sq    = Q_W'(cand) * Q_W'(cand);

  assign sts.skip     = few_r || (d_r == '0);
  assign sts.sat      = ({(D_W + Q_W - 2*DEV_W - Z_W)'(0), devsq_r, Z_W'(0)})
                        >= {d_r, Q_W'(0)};
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_r <= hist_mem[old_idx];
    end
    if (cmd.acc) begin
      hist_mem[slot_r] <= x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WINDOW_RESET;
      thresh_r    <= THRESH_RESET;
      held_r      <= '0;
      slot_r      <= '0;
      sum_r       <= '0;
      sqs_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_WINDOW_SIZE: begin
            window_r <= cfg_wdata[WIN_REG_W-1:0];
            held_r   <= '0;
            slot_r   <= '0;
            sum_r    <= '0;
            sqs_r    <= '0;
          end
          CFG_Z_THRESHOLD: begin
            thresh_r <= cfg_wdata[THR_W-1:0];
          end
        endcase
      end else if (cmd.acc) begin
        slot_r <= slot_r + 1'b1;
        held_r <= held_r - CNT_W'(evict_r) + 1'b1;
        sum_r  <= sum_r - SUM_W'(old_r) + SUM_W'(x_r);
        sqs_r  <= sqs_r - SQS_W'(oldsq_r) + SQS_W'(xsq_r);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r     <= in_sample;
      evict_r <= (held_r >= win);
    end
    if (cmd.sq) begin
      old_r   <= evict_r ? rd_r : '0;
      oldsq_r <= evict_r ? (2*SAMPLE_W)'(rd_r) * (2*SAMPLE_W)'(rd_r) : '0;
      xsq_r   <= (2*SAMPLE_W)'(x_r) * (2*SAMPLE_W)'(x_r);
    end
    if (cmd.mul) begin
      nq_r <= D_W'(held_r) * D_W'(sqs_r);
      s2_r <= (2*SUM_W)'(sum_r) * (2*SUM_W)'(sum_r);
      nx_r <= (SUM_W+1)'(held_r) * (SUM_W+1)'(x_r);
    end
    if (cmd.dev) begin
      d_r   <= nq_r - D_W'(s2_r);
      few_r <= (held_r < CNT_W'(3));
      if (nx_r >= (SUM_W+1)'(sum_r)) begin
        dev_r <= DEV_W'(nx_r - (SUM_W+1)'(sum_r));
      end else begin
        dev_r <= DEV_W'((SUM_W+1)'(sum_r) - nx_r);
      end
    end
    if (cmd.mul2) begin
      devsq_r <= (2*DEV_W)'(dev_r) * (2*DEV_W)'(dev_r);
      t2_r    <= Q_W'(thresh_r) * Q_W'(thresh_r);
    end
    if (cmd.chk) begin
      rem_r <= D_W'(devsq_r[2*DEV_W-1:Q_W-Z_W]);
      num_r <= {devsq_r[Q_W-Z_W-1:0], Z_W'(0)};
      q_r   <= '0;
      k_r   <= '0;
      bit_r <= {1'b1, (Z_W-1)'(0)};
      if (sts.skip) begin
        z_r      <= '0;
        anom_r   <= 1'b0;
        scored_r <= 1'b0;
      end else if (sts.sat) begin
        z_r      <= '1;
        anom_r   <= 1'b1;
        scored_r <= 1'b1;
      end
    end
    if (cmd.div) begin
      num_r <= {num_r[Q_W-2:0], 1'b0};
      if (!trial_diff[D_W]) begin
        rem_r <= trial_diff[D_W-1:0];
        q_r   <= {q_r[Q_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[D_W-1:0];
        q_r   <= {q_r[Q_W-2:0], 1'b0};
      end
    end
    if (cmd.sqrt) begin
      bit_r <= bit_r >> 1;
      if (cand_sq <= q_r) begin
        k_r <= cand;
      end
    end
    if (cmd.fin) begin
      z_r      <= k_r;
      anom_r   <= (q_r > t2_r) || ((q_r == t2_r) && (rem_r != '0));
      scored_r <= 1'b1;
    end
    if (cmd.load_out) begin
      out_z_r      <= z_r;
      out_anom_r   <= anom_r;
      out_scored_r <= scored_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_z_score = out_z_r;
  assign out_anomaly = out_anom_r;
  assign out_scored  = out_scored_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(WINDOW_MAX))
    else $error("held count above ring depth");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div |-> (rem_r < d_r))
    else $error("divider remainder not below divisor");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

// File: design/sliding_window_zscore_detector.sv
// ----------------------------------------------------------------------------
// sliding_window_zscore_detector: streaming z-score anomaly detector
// Keeps a ring of recent samples with running sum and sum of squares and
// scores each new sample against the window as an unsigned 8.8 z-score.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake          | Word contents
//  ---------+-----------+--------------------+-----------------------------------
//  in_      | input     | in_valid/in_stall  | sample (u8.8)
//  out_     | output    | out_valid/out_stall| z_score (u8.8), anomaly, scored
//  cfg_     | input     | cfg_we             | index 0 window_size, 1 z_threshold
//
// One word is processed at a time. A scored word passes from acceptance to the
// output register through ring update, products and checks, the one-bit-per-
// cycle divider, the one-bit-per-cycle square root, a finish step and the load.
// Unscored or saturated words skip the divider and square root. The next word
// can be taken in the cycle after the load, so each word ends before the next.
// Reset (synchronous, active low) empties the window and loads window 60 and
// threshold 3.0. A stalled output holds the finished word and keeps the next
// input stalled until the result register is free.
//
// The z-score is found exactly: q = floor(65536*dev^2 / D) with
// D = n*Q - S^2, then z = floor(sqrt(q)). When q would reach 2^32 the score
// saturates and the anomaly flag is set, since no 16-bit threshold squared
// reaches that value. Otherwise the anomaly flag compares q and the remainder
// against the squared threshold, which matches the exact comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_zscore_detector
  import swz_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [Z_W-1:0]           out_z_score,
  output logic                     out_anomaly,
  output logic                     out_scored,
  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // The controller only sequences; all state of the window lives in the
  // datapath.
  swz_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  swz_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_sample   (in_sample),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_z_score (out_z_score),
    .out_anomaly (out_anomaly),
    .out_scored  (out_scored)
  );

endmodule

`default_nettype wire
